// ===== sv/cfl_time_step_limiter_macros.svh =====
// Assertion macros used by the checker file of the time step limiter.
`ifndef CFL_TIME_STEP_LIMITER_MACROS_SVH
`define CFL_TIME_STEP_LIMITER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CFL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfl_time_step_limiter: assertion failed");

// The condition must hold in the cycle after the trigger.
`define CFL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfl_time_step_limiter: assertion failed");

`endif

// ===== sv/cfl_tsl_pkg.sv =====
package cfl_tsl_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_COURANT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROWTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP = 3'd3;

    localparam logic [WORD_W-1:0] RST_COURANT  = 32'd65536;
    localparam logic [WORD_W-1:0] RST_PREV     = 32'd65536;
    localparam logic [WORD_W-1:0] RST_GROWTH   = 32'd72090;
    localparam logic [WORD_W-1:0] RST_MIN_STEP = 32'd0;

    localparam logic [WORD_W:0]   Q_ONE_MILLI = 33'd66;
    localparam logic [WORD_W-1:0] Q_TEN       = 32'd655360;

    typedef struct packed {
        logic signed [WORD_W-1:0] velocity;
        logic signed [WORD_W-1:0] celerity;
        logic        [WORD_W-1:0] cell_length;
        logic                     is_last;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0] cell_step;
        logic [WORD_W-1:0] next_step;
        logic              step_valid;
    } t_out_beat;

    typedef struct packed {
        logic [WORD_W-1:0] courant_number;
        logic [WORD_W-1:0] previous_step;
        logic [WORD_W-1:0] growth_factor;
        logic [WORD_W-1:0] minimum_step;
    } t_cfg;

    typedef struct packed {
        logic [2*WORD_W-1:0] num;
        logic [WORD_W:0]     speed;
        logic                is_last;
    } t_job;

endpackage

// ===== sv/cfl_tsl_front.sv =====
module cfl_tsl_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfl_tsl_pkg::t_cfg     i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cfl_tsl_pkg::t_in_beat i_in_data,
    output logic                  o_push,
    output cfl_tsl_pkg::t_job     o_job,
    input  logic                  i_full
);
    import cfl_tsl_pkg::*;

    logic                 r_v;
    t_in_beat             r_in;
    logic signed [WORD_W:0] w_sum;
    logic signed [WORD_W:0] w_diff;
    logic [WORD_W:0]      w_mag_sum;
    logic [WORD_W:0]      w_mag_diff;
    logic [WORD_W:0]      w_speed;

    assign w_sum  = {r_in.velocity[WORD_W-1], r_in.velocity}
                  + {r_in.celerity[WORD_W-1], r_in.celerity};
    assign w_diff = {r_in.velocity[WORD_W-1], r_in.velocity}
                  - {r_in.celerity[WORD_W-1], r_in.celerity};

    assign w_mag_sum  = w_sum[WORD_W]  ? (~w_sum + 1'b1)  : w_sum;
    assign w_mag_diff = w_diff[WORD_W] ? (~w_diff + 1'b1) : w_diff;

    always_comb begin
        w_speed = (w_mag_sum > w_mag_diff) ? w_mag_sum : w_mag_diff;
        if (w_speed < Q_ONE_MILLI) begin
            w_speed = Q_ONE_MILLI;
        end
    end

    assign o_in_stall    = r_v && i_full;
    assign o_push        = r_v && !i_full;
    assign o_job.num     = {{WORD_W{1'b0}}, i_cfg.courant_number}
                         * {{WORD_W{1'b0}}, r_in.cell_length};
    assign o_job.speed   = w_speed;
    assign o_job.is_last = r_in.is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

endmodule

// ===== sv/cfl_tsl_queue.sv =====
module cfl_tsl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cfl_tsl_pkg::t_job i_job,
    output logic              o_full,
    input  logic              i_pop,
    output cfl_tsl_pkg::t_job o_job,
    output logic              o_empty
);
    import cfl_tsl_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== sv/cfl_tsl_back.sv =====
module cfl_tsl_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cfl_tsl_pkg::t_cfg      i_cfg,
    input  logic                   i_empty,
    input  cfl_tsl_pkg::t_job      i_job,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output cfl_tsl_pkg::t_out_beat o_out_data
);
    import cfl_tsl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W:0]     r_rem;
    logic [WORD_W-1:0]   r_quo;
    logic [WORD_W:0]     r_speed;
    logic                r_last;
    logic [WORD_W-1:0]   r_min;
    logic                r_start;
    logic [WORD_W-1:0]   r_cap;
    logic [WORD_W-1:0]   r_limit;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic [WORD_W+1:0]   w_trial;
    logic                w_ge;
    logic [WORD_W:0]     n_rem;
    logic                w_sat;
    logic                w_take_ok;
    logic [WORD_W-1:0]   w_min;
    logic [WORD_W-1:0]   w_dt_lim;
    logic [WORD_W-1:0]   w_dt_floor;
    logic [WORD_W-1:0]   w_dt;
    logic [2*WORD_W-1:0] w_prod;
    logic [WORD_W:0]     w_lsum;

    assign w_trial = {r_rem, r_quo[WORD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_speed});
    assign n_rem   = w_ge ? (WORD_W+1)'(w_trial - {1'b0, r_speed}) : w_trial[WORD_W:0];
    assign w_sat   = ({1'b0, i_job.num[2*WORD_W-1:WORD_W]} >= i_job.speed);

    assign w_prod = {{WORD_W{1'b0}}, i_cfg.previous_step}
                  * {{WORD_W{1'b0}}, i_cfg.growth_factor};
    assign w_lsum = {1'b0, i_cfg.previous_step} + {1'b0, Q_TEN};

    assign w_min      = (r_start || (r_quo < r_min)) ? r_quo : r_min;
    assign w_dt_lim   = (w_min < r_limit) ? w_min : r_limit;
    assign w_dt_floor = (w_dt_lim < i_cfg.minimum_step) ? i_cfg.minimum_step : w_dt_lim;
    assign w_dt       = (r_cap < w_dt_floor) ? r_cap : w_dt_floor;

    assign w_take_ok   = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_start     <= 1'b1;
        end else begin
            r_cap   <= (|w_prod[2*WORD_W-1:WORD_W+16]) ? '1 : w_prod[WORD_W+15:16];
            r_limit <= w_lsum[WORD_W] ? '1 : w_lsum[WORD_W-1:0];
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_rem   <= {1'b0, i_job.num[2*WORD_W-1:WORD_W]};
                        r_speed <= i_job.speed;
                        r_last  <= i_job.is_last;
                        r_cnt   <= DIV_CNT_W'(DIV_STEPS - 1);
                        if (w_sat) begin
                            r_quo   <= '1;
                            r_state <= S_FIN;
                        end else begin
                            r_quo   <= i_job.num[WORD_W-1:0];
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[WORD_W-2:0], w_ge};
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FIN: begin
                    if (w_take_ok) begin
                        r_out_valid      <= 1'b1;
                        r_out.cell_step  <= r_quo;
                        r_out.next_step  <= r_last ? w_dt : '0;
                        r_out.step_valid <= r_last;
                        r_min            <= w_min;
                        r_start          <= r_last;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/cfl_time_step_limiter.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (velocity, celerity, length, last)
// output    out        o_out_valid / i_out_stall o_out_data (cell step, next step, flag)
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// Each cell beat holds the back end while it loads the divider, runs the 32 steps of the
// radix-2 restoring divider, and folds the sweep minimum and drives the output register;
// a saturating quotient skips the divider steps; the last step waits while the output stalls.
// A cell beat passes the front register, the queue, the divider and the output register in turn.
// The front register and the two-entry queue hold up to three cells while the divider is busy.
// Reset is synchronous and active low; it restores the register defaults and starts a sweep.
module cfl_time_step_limiter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cfl_tsl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cfl_tsl_pkg::WORD_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cfl_tsl_pkg::t_in_beat               i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cfl_tsl_pkg::t_out_beat              o_out_data
);
    import cfl_tsl_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_pop_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.courant_number <= RST_COURANT;
            r_cfg.previous_step  <= RST_PREV;
            r_cfg.growth_factor  <= RST_GROWTH;
            r_cfg.minimum_step   <= RST_MIN_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COURANT:  r_cfg.courant_number <= i_cfg_data;
                REG_PREV:     r_cfg.previous_step  <= i_cfg_data;
                REG_GROWTH:   r_cfg.growth_factor  <= i_cfg_data;
                REG_MIN_STEP: r_cfg.minimum_step   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cfl_tsl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_full     (w_full)
    );

    cfl_tsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    cfl_tsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/cfl_tsl_checker.sv =====
`include "cfl_time_step_limiter_macros.svh"

module cfl_tsl_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input cfl_tsl_pkg::t_out_beat o_out_data
);
    import cfl_tsl_pkg::*;

    `CFL_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `CFL_ASSERT_IMP(a_next_zero, o_out_valid && !o_out_data.step_valid, o_out_data.next_step == '0)
    `CFL_ASSERT_IMP(a_stall_cause, o_in_stall, $past(i_in_valid && !o_in_stall) || $past(o_in_stall))

endmodule

bind cfl_time_step_limiter cfl_tsl_checker u_cfl_tsl_checker (.*);
